[rtl/core/pws_pkg.sv]
package pws_pkg;

    localparam int COORD_W       = 32;
    localparam int SIZE_W        = 14;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int FRAC_BITS_DEF = 16;
    localparam int QUO_W         = 32;

    // visible when clip w >= 1/VIS_RECIP
    localparam int VIS_RECIP = 100;

    localparam logic [QUO_W-1:0] SAT_POS = {1'b0, {(QUO_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] SAT_NEG = {1'b1, {(QUO_W-1){1'b0}}};

    localparam logic [CFG_W-1:0]  ROW_X_XY_RST = 64'd65536;
    localparam logic [CFG_W-1:0]  ROW_X_ZT_RST = 64'd0;
    localparam logic [CFG_W-1:0]  ROW_Y_XY_RST = 64'd281474976710656;
    localparam logic [CFG_W-1:0]  ROW_Y_ZT_RST = 64'd0;
    localparam logic [CFG_W-1:0]  ROW_W_XY_RST = 64'd0;
    localparam logic [CFG_W-1:0]  ROW_W_ZT_RST = 64'd281474976710656;
    localparam logic [SIZE_W-1:0] WIDTH_RST    = 14'd1920;
    localparam logic [SIZE_W-1:0] HEIGHT_RST   = 14'd1080;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_X_XY = 3'd0,
        CFG_ROW_X_ZT = 3'd1,
        CFG_ROW_Y_XY = 3'd2,
        CFG_ROW_Y_ZT = 3'd3,
        CFG_ROW_W_XY = 3'd4,
        CFG_ROW_W_ZT = 3'd5,
        CFG_SCREEN_W = 3'd6,
        CFG_SCREEN_H = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] row_x_xy;
        logic [CFG_W-1:0] row_x_zt;
        logic [CFG_W-1:0] row_y_xy;
        logic [CFG_W-1:0] row_y_zt;
        logic [CFG_W-1:0] row_w_xy;
        logic [CFG_W-1:0] row_w_zt;
    } matrix_t;

    // per-point flags riding along the divider; neg[0] is x, neg[1] is y
    typedef struct packed {
        logic       visible;
        logic [1:0] neg;
    } side_t;

    typedef struct packed {
        logic                      visible;
        logic signed [COORD_W-1:0] screen_x;
        logic signed [COORD_W-1:0] screen_y;
    } result_t;

endpackage

[rtl/core/pws_clip.sv]
module pws_clip #(
    parameter int FRAC_BITS = pws_pkg::FRAC_BITS_DEF,
    localparam int CLIP_W = 2 * pws_pkg::COORD_W + 2 - FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [pws_pkg::COORD_W-1:0] world_x,
    input  logic signed [pws_pkg::COORD_W-1:0] world_y,
    input  logic signed [pws_pkg::COORD_W-1:0] world_z,
    input  pws_pkg::matrix_t                  mat,
    output logic                              out_valid,
    output logic signed [CLIP_W-1:0]          clip_x,
    output logic signed [CLIP_W-1:0]          clip_y,
    output logic signed [CLIP_W-1:0]          clip_w
);
    import pws_pkg::*;

    localparam int PROD_W = 2 * COORD_W;
    localparam int SH_W   = PROD_W - FRAC_BITS;
    localparam int PAIR_W = SH_W + 1;

    // rows: 0 = x, 1 = y, 2 = w; columns: world x, y, z
    logic signed [COORD_W-1:0] pt [3];
    logic signed [COORD_W-1:0] coef [3][3];
    logic signed [COORD_W-1:0] trans [3];
    logic signed [PROD_W-1:0]  prod_reg [3][3];
    logic signed [SH_W-1:0]    sh [3][3];
    logic signed [PAIR_W-1:0]  pair_a_next [3];
    logic signed [PAIR_W-1:0]  pair_b_next [3];
    logic signed [PAIR_W-1:0]  pair_a_reg [3];
    logic signed [PAIR_W-1:0]  pair_b_reg [3];
    logic signed [CLIP_W-1:0]  clip_reg [3];
    logic                      v1_reg, v2_reg, v3_reg;

    always_comb begin
        pt[0] = world_x;
        pt[1] = world_y;
        pt[2] = world_z;
        coef[0][0] = mat.row_x_xy[COORD_W-1:0];
        coef[0][1] = mat.row_x_xy[CFG_W-1:COORD_W];
        coef[0][2] = mat.row_x_zt[COORD_W-1:0];
        trans[0]   = mat.row_x_zt[CFG_W-1:COORD_W];
        coef[1][0] = mat.row_y_xy[COORD_W-1:0];
        coef[1][1] = mat.row_y_xy[CFG_W-1:COORD_W];
        coef[1][2] = mat.row_y_zt[COORD_W-1:0];
        trans[1]   = mat.row_y_zt[CFG_W-1:COORD_W];
        coef[2][0] = mat.row_w_xy[COORD_W-1:0];
        coef[2][1] = mat.row_w_xy[CFG_W-1:COORD_W];
        coef[2][2] = mat.row_w_zt[COORD_W-1:0];
        trans[2]   = mat.row_w_zt[CFG_W-1:COORD_W];
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                // arithmetic shift floors toward minus infinity
                sh[r][c] = prod_reg[r][c][PROD_W-1:FRAC_BITS];
            end
            pair_a_next[r] = PAIR_W'(sh[r][0]) + PAIR_W'(sh[r][1]);
            pair_b_next[r] = PAIR_W'(sh[r][2]) + PAIR_W'(trans[r]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[r][c] <= coef[r][c] * pt[c];
                end
                pair_a_reg[r] <= pair_a_next[r];
                pair_b_reg[r] <= pair_b_next[r];
                clip_reg[r]   <= CLIP_W'(pair_a_reg[r]) + CLIP_W'(pair_b_reg[r]);
            end
        end
    end

    assign out_valid = v3_reg;
    assign clip_x    = clip_reg[0];
    assign clip_y    = clip_reg[1];
    assign clip_w    = clip_reg[2];

endmodule

[rtl/core/pws_scale.sv]
module pws_scale #(
    parameter int FRAC_BITS = pws_pkg::FRAC_BITS_DEF,
    localparam int CLIP_W = 2 * pws_pkg::COORD_W + 2 - FRAC_BITS,
    localparam int NUM_W  = CLIP_W + 1 + pws_pkg::SIZE_W + FRAC_BITS + 1,
    localparam int DEN_W  = CLIP_W
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [CLIP_W-1:0]         clip_x,
    input  logic signed [CLIP_W-1:0]         clip_y,
    input  logic signed [CLIP_W-1:0]         clip_w,
    input  logic [pws_pkg::SIZE_W-1:0]       screen_width,
    input  logic [pws_pkg::SIZE_W-1:0]       screen_height,
    output logic                             out_valid,
    output logic [NUM_W-1:0]                 num [2],
    output logic [DEN_W-1:0]                 den,
    output pws_pkg::side_t                   side
);
    import pws_pkg::*;

    localparam int A_W   = CLIP_W + 1;
    localparam int MAG_W = A_W;
    localparam int W_W   = CLIP_W - 1;
    localparam int ML    = MAG_W / 2;
    localparam int MH    = MAG_W - ML;
    localparam int LO_P  = ML + SIZE_W;
    localparam int HI_P  = MH + SIZE_W;
    localparam int PM_W  = MAG_W + SIZE_W;
    localparam logic signed [CLIP_W-1:0] VIS_MIN =
        CLIP_W'(((longint'(1) <<< FRAC_BITS) + VIS_RECIP - 1) / VIS_RECIP);

    // lane 0 carries x, lane 1 carries y
    logic [SIZE_W-1:0]       size [2];
    logic signed [A_W-1:0]   a_next [2];
    logic signed [A_W-1:0]   a_reg [2];
    logic                    vis4_reg;
    logic signed [CLIP_W-1:0] w4_reg;
    logic [MAG_W-1:0]        mag_next [2];
    logic [MAG_W-1:0]        mag5_reg [2];
    side_t                   side5_reg, side6_reg, side7_reg, side8_reg;
    logic [W_W-1:0]          w5_reg, w6_reg, w7_reg;
    logic [LO_P-1:0]         pl_next [2];
    logic [HI_P-1:0]         ph_next [2];
    logic [LO_P-1:0]         pl6_reg [2];
    logic [HI_P-1:0]         ph6_reg [2];
    logic [PM_W-1:0]         pm7_reg [2];
    logic [NUM_W-1:0]        num_reg [2];
    logic [DEN_W-1:0]        den_reg;
    logic                    v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;

    always_comb begin
        size[0] = screen_width;
        size[1] = screen_height;
        // x uses w + x, y uses w - y (y flipped)
        a_next[0] = A_W'(clip_w) + A_W'(clip_x);
        a_next[1] = A_W'(clip_w) - A_W'(clip_y);
        for (int l = 0; l < 2; l++) begin
            mag_next[l] = a_reg[l][A_W-1] ? unsigned'(-a_reg[l]) : unsigned'(a_reg[l]);
            pl_next[l]  = LO_P'(mag5_reg[l][ML-1:0]) * LO_P'(size[l]);
            ph_next[l]  = HI_P'(mag5_reg[l][MAG_W-1:ML]) * HI_P'(size[l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vis4_reg          <= clip_w >= VIS_MIN;
            w4_reg            <= clip_w;
            side5_reg.visible <= vis4_reg;
            w5_reg            <= w4_reg[W_W-1:0];
            side6_reg         <= side5_reg;
            w6_reg            <= w5_reg;
            side7_reg         <= side6_reg;
            w7_reg            <= w6_reg;
            side8_reg         <= side7_reg;
            den_reg           <= {w7_reg, 1'b0};
            for (int l = 0; l < 2; l++) begin
                a_reg[l]         <= a_next[l];
                side5_reg.neg[l] <= a_reg[l][A_W-1];
                mag5_reg[l]      <= mag_next[l];
                pl6_reg[l]       <= pl_next[l];
                ph6_reg[l]       <= ph_next[l];
                pm7_reg[l]       <= (PM_W'(ph6_reg[l]) << ML) + PM_W'(pl6_reg[l]);
                // 2 * size * |a| * 2^(F-1) + w
                num_reg[l]       <= NUM_W'({pm7_reg[l], {FRAC_BITS{1'b0}}}) + NUM_W'(w7_reg);
            end
        end
    end

    assign out_valid = v8_reg;
    assign num       = num_reg;
    assign den       = den_reg;
    assign side      = side8_reg;

endmodule

[rtl/core/pws_div.sv]
module pws_div #(
    parameter int FRAC_BITS = pws_pkg::FRAC_BITS_DEF,
    localparam int CLIP_W = 2 * pws_pkg::COORD_W + 2 - FRAC_BITS,
    localparam int NUM_W  = CLIP_W + 1 + pws_pkg::SIZE_W + FRAC_BITS + 1,
    localparam int DEN_W  = CLIP_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [NUM_W-1:0]   num [2],
    input  logic [DEN_W-1:0]   den,
    input  pws_pkg::side_t     side,
    output logic               out_valid,
    output pws_pkg::result_t   res
);
    import pws_pkg::*;

    localparam int STEPS = QUO_W;
    localparam int HI_W  = NUM_W - QUO_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [CMP_W-1:0] hi_ext [2];
    logic [1:0]       ovf_next;
    logic [DEN_W-1:0] rem_reg [STEPS+1][2];
    logic [QUO_W-1:0] qn_reg [STEPS+1][2];
    logic [DEN_W-1:0] den_reg [STEPS+1];
    side_t            side_reg [STEPS+1];
    logic [1:0]       ovf_reg [STEPS+1];
    logic             vld_reg [STEPS+1];
    logic [QUO_W-1:0] cap [2];
    logic [QUO_W-1:0] sat_next [2];
    logic [QUO_W-1:0] sat_reg [2];
    side_t            sat_side_reg;
    logic             sat_vld_reg;
    logic [QUO_W-1:0] fin_next [2];
    result_t          res_reg;
    logic             res_vld_reg;

    // quotient past 32 bits saturates; otherwise the upper part seeds the remainder
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            hi_ext[l]   = CMP_W'(num[l][NUM_W-1:QUO_W]);
            ovf_next[l] = hi_ext[l] >= CMP_W'(den);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 2; l++) begin
                rem_reg[0][l] <= hi_ext[l][DEN_W-1:0];
                qn_reg[0][l]  <= num[l][QUO_W-1:0];
            end
            den_reg[0]  <= den;
            side_reg[0] <= side;
            ovf_reg[0]  <= ovf_next;
        end
    end

    // one restoring step per stage; numerator bits shift out as quotient bits shift in
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [DEN_W:0] rem_sh [2];
        logic [DEN_W:0] diff [2];
        logic [1:0]     ge;

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                rem_sh[l] = {rem_reg[k][l], qn_reg[k][l][QUO_W-1]};
                diff[l]   = rem_sh[l] - {1'b0, den_reg[k]};
                ge[l]     = rem_sh[l] >= {1'b0, den_reg[k]};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < 2; l++) begin
                    rem_reg[k+1][l] <= ge[l] ? diff[l][DEN_W-1:0] : rem_sh[l][DEN_W-1:0];
                    qn_reg[k+1][l]  <= {qn_reg[k][l][QUO_W-2:0], ge[l]};
                end
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            cap[l] = side_reg[STEPS].neg[l] ? SAT_NEG : SAT_POS;
            if (ovf_reg[STEPS][l] || (qn_reg[STEPS][l] > cap[l])) begin
                sat_next[l] = cap[l];
            end else begin
                sat_next[l] = qn_reg[STEPS][l];
            end
            if (!sat_side_reg.visible) begin
                fin_next[l] = '0;
            end else if (sat_side_reg.neg[l]) begin
                fin_next[l] = -sat_reg[l];
            end else begin
                fin_next[l] = sat_reg[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end else if (en) begin
            sat_vld_reg <= vld_reg[STEPS];
            res_vld_reg <= sat_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sat_reg[0]       <= sat_next[0];
            sat_reg[1]       <= sat_next[1];
            sat_side_reg     <= side_reg[STEPS];
            res_reg.visible  <= sat_side_reg.visible;
            res_reg.screen_x <= fin_next[0];
            res_reg.screen_y <= fin_next[1];
        end
    end

    assign out_valid = res_vld_reg;
    assign res       = res_reg;

endmodule

[rtl/core/perspective_world_to_screen.sv]
// Channel   Dir  Handshake            Payload
// s_        in   s_valid / s_ready    s_world_x, s_world_y, s_world_z (signed fixed point)
// m_        out  m_valid / m_ready    m_visible, m_screen_x, m_screen_y (signed fixed point)
// cfg_      in   cfg_wr_en            cfg_index, cfg_data (write only, no wait)
//
// One point per clock sustained while the skid slot is empty; the restoring divider
// produces one quotient bit per stage.
// aresetn (synchronous, active low) clears every valid bit and loads the default matrix
// (identity x and y, w = constant 1.0) and a 1920 x 1080 screen.
// A stalled m_ready first fills a one-word skid slot, then freezes every pipeline stage.
module perspective_world_to_screen #(
    parameter int FRAC_BITS = pws_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [pws_pkg::COORD_W-1:0] s_world_x,
    input  logic signed [pws_pkg::COORD_W-1:0] s_world_y,
    input  logic signed [pws_pkg::COORD_W-1:0] s_world_z,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_visible,
    output logic signed [pws_pkg::COORD_W-1:0] m_screen_x,
    output logic signed [pws_pkg::COORD_W-1:0] m_screen_y,
    input  logic                               cfg_wr_en,
    input  logic [pws_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pws_pkg::CFG_W-1:0]          cfg_data
);
    import pws_pkg::*;

    localparam int CLIP_W = 2 * COORD_W + 2 - FRAC_BITS;
    localparam int NUM_W  = CLIP_W + 1 + SIZE_W + FRAC_BITS + 1;
    localparam int DEN_W  = CLIP_W;

    matrix_t            mat_reg;
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;

    logic               en;
    logic               clip_valid;
    logic signed [CLIP_W-1:0] clip_x, clip_y, clip_w;
    logic               scale_valid;
    logic [NUM_W-1:0]   num [2];
    logic [DEN_W-1:0]   den;
    side_t              side;
    logic               pipe_valid;
    result_t            pipe_res;

    result_t            out_reg, skid_reg;
    logic               out_valid_reg, skid_valid_reg;
    logic               out_valid_next, skid_valid_next;
    logic               load_out, load_skid, out_from_skid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_reg.row_x_xy <= ROW_X_XY_RST;
            mat_reg.row_x_zt <= ROW_X_ZT_RST;
            mat_reg.row_y_xy <= ROW_Y_XY_RST;
            mat_reg.row_y_zt <= ROW_Y_ZT_RST;
            mat_reg.row_w_xy <= ROW_W_XY_RST;
            mat_reg.row_w_zt <= ROW_W_ZT_RST;
            width_reg        <= WIDTH_RST;
            height_reg       <= HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROW_X_XY: mat_reg.row_x_xy <= cfg_data;
                CFG_ROW_X_ZT: mat_reg.row_x_zt <= cfg_data;
                CFG_ROW_Y_XY: mat_reg.row_y_xy <= cfg_data;
                CFG_ROW_Y_ZT: mat_reg.row_y_zt <= cfg_data;
                CFG_ROW_W_XY: mat_reg.row_w_xy <= cfg_data;
                CFG_ROW_W_ZT: mat_reg.row_w_zt <= cfg_data;
                CFG_SCREEN_W: width_reg        <= cfg_data[SIZE_W-1:0];
                CFG_SCREEN_H: height_reg       <= cfg_data[SIZE_W-1:0];
            endcase
        end
    end

    // the whole pipeline advances together; only a full skid slot holds it
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    pws_clip #(
        .FRAC_BITS(FRAC_BITS)
    ) u_clip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .world_x   (s_world_x),
        .world_y   (s_world_y),
        .world_z   (s_world_z),
        .mat       (mat_reg),
        .out_valid (clip_valid),
        .clip_x    (clip_x),
        .clip_y    (clip_y),
        .clip_w    (clip_w)
    );

    pws_scale #(
        .FRAC_BITS(FRAC_BITS)
    ) u_scale (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (clip_valid),
        .clip_x        (clip_x),
        .clip_y        (clip_y),
        .clip_w        (clip_w),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .out_valid     (scale_valid),
        .num           (num),
        .den           (den),
        .side          (side)
    );

    pws_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (scale_valid),
        .num       (num),
        .den       (den),
        .side      (side),
        .out_valid (pipe_valid),
        .res       (pipe_res)
    );

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        out_from_skid   = 1'b0;
        priority if (skid_valid_reg) begin
            if (m_ready) begin
                out_from_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (pipe_valid) begin
            if (!out_valid_reg || m_ready) begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end else begin
                // park the word while the output is held
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            // hold the output word
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_from_skid) begin
            out_reg <= skid_reg;
        end else if (load_out) begin
            out_reg <= pipe_res;
        end
        if (load_skid) begin
            skid_reg <= pipe_res;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_visible  = out_reg.visible;
    assign m_screen_x = out_reg.screen_x;
    assign m_screen_y = out_reg.screen_y;

endmodule
